>>> rtl/ipv4ad_pkg.sv
// Shared types and constants for the IPv4 dotted-quad address detector.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package ipv4ad_pkg;

    localparam int unsigned TEXT_W    = 8;
    localparam int unsigned OFFSET_W  = 32;
    localparam int unsigned LENGTH_W  = 4;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned OCTET_W   = 10;
    localparam int unsigned DIGITS_W  = 2;
    localparam int unsigned INDEX_W   = 2;

    localparam logic [TEXT_W-1:0]   CHAR_DOT    = 8'h2E;
    localparam logic [TEXT_W-1:0]   CHAR_0      = 8'h30;
    localparam logic [TEXT_W-1:0]   CHAR_9      = 8'h39;
    localparam logic [TEXT_W-1:0]   CHAR_LO_A   = 8'h61;
    localparam logic [TEXT_W-1:0]   CHAR_LO_Z   = 8'h7A;
    localparam logic [TEXT_W-1:0]   CHAR_UP_A   = 8'h41;
    localparam logic [TEXT_W-1:0]   CHAR_UP_Z   = 8'h5A;
    localparam logic [OCTET_W-1:0]  OCTET_MAX   = 10'd255;
    localparam logic [DIGITS_W-1:0] DIGITS_MAX  = 2'd3;
    localparam logic [INDEX_W-1:0]  INDEX_LAST  = 2'd3;
    localparam int unsigned         PAD_W       = M_TDATA_W - OFFSET_W - LENGTH_W;

    typedef struct packed {
        logic [OFFSET_W-1:0] match_offset;
        logic [LENGTH_W-1:0] match_length;
    } match_t;

    typedef struct packed {
        logic [TEXT_W-1:0] text_byte;
        logic              last_byte;
    } text_item_t;

    function automatic logic num_char(input logic [TEXT_W-1:0] c);
        return (c >= CHAR_0) && (c <= CHAR_9);
    endfunction

    function automatic logic word_char(input logic [TEXT_W-1:0] c);
        return num_char(c) || ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z))
            || ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z));
    endfunction

endpackage

`default_nettype wire

>>> rtl/ipv4ad_in_reg.sv
// Input register stage of the IPv4 address detector: captures one text byte per transfer.
// Depends on ipv4ad_pkg.
`default_nettype none

module ipv4ad_in_reg (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire ipv4ad_pkg::text_item_t  s_item,
    input  wire logic                    advance,
    output logic                         item_valid,
    output ipv4ad_pkg::text_item_t       item
);
    import ipv4ad_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    text_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> rtl/ipv4ad_parse.sv
// Dotted-quad parser state and its one-byte update step.
// Depends on ipv4ad_pkg.
`default_nettype none

module ipv4ad_parse #(
    parameter int unsigned POSITION_BITS = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   step_en,
    input  wire ipv4ad_pkg::text_item_t item,
    output logic                        emit,
    output ipv4ad_pkg::match_t          match
);
    import ipv4ad_pkg::*;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic                     allowed_reg, allowed_next;
    logic                     active_reg, active_next;
    logic [INDEX_W-1:0]       index_reg, index_next;
    logic [DIGITS_W-1:0]      digits_reg, digits_next;
    logic [OCTET_W-1:0]       value_reg, value_next;

    logic                     dig;
    logic                     dot;
    logic [OCTET_W-1:0]       digit_val;
    logic [OCTET_W-1:0]       times_ten;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [LENGTH_W-1:0]      end_low;
    logic                     done_cur;
    logic                     done_next;

    assign dig       = num_char(item.text_byte);
    assign dot       = (item.text_byte == CHAR_DOT);
    assign digit_val = OCTET_W'(item.text_byte - CHAR_0);
    assign times_ten = {value_reg[OCTET_W-4:0], 3'b000} + {value_reg[OCTET_W-2:0], 1'b0};
    assign pos_inc   = pos_reg + 1'b1;
    assign done_cur  = (index_reg == INDEX_LAST) && (digits_reg != '0)
                    && (value_reg <= OCTET_MAX);

    always_comb begin
        active_next  = active_reg;
        start_next   = start_reg;
        index_next   = index_reg;
        digits_next  = digits_reg;
        value_next   = value_reg;
        emit         = 1'b0;
        end_low      = pos_reg[LENGTH_W-1:0];
        if (active_reg) begin
            if (dig) begin
                if (digits_reg < DIGITS_MAX) begin
                    value_next  = times_ten + digit_val;
                    digits_next = digits_reg + 1'b1;
                end else begin
                    active_next = 1'b0;
                end
            end else if (dot) begin
                if ((digits_reg == '0) || (value_reg > OCTET_MAX)
                        || (index_reg == INDEX_LAST)) begin
                    active_next = 1'b0;
                end else begin
                    index_next  = index_reg + 1'b1;
                    digits_next = '0;
                    value_next  = '0;
                end
            end else begin
                emit        = done_cur;
                active_next = 1'b0;
            end
        end else if (dig && allowed_reg) begin
            active_next = 1'b1;
            start_next  = pos_reg;
            index_next  = '0;
            digits_next = DIGITS_W'(1);
            value_next  = digit_val;
        end

        allowed_next = !(word_char(item.text_byte) || dot);
        done_next    = (index_next == INDEX_LAST) && (digits_next != '0)
                    && (value_next <= OCTET_MAX);

        if (item.last_byte) begin
            if (active_next && done_next) begin
                emit    = 1'b1;
                end_low = pos_inc[LENGTH_W-1:0];
            end
            active_next  = 1'b0;
            index_next   = '0;
            digits_next  = '0;
            value_next   = '0;
            allowed_next = 1'b1;
            pos_next     = '0;
        end else begin
            pos_next = pos_inc;
        end
    end

    assign match.match_offset = OFFSET_W'(start_next);
    assign match.match_length = end_low - start_next[LENGTH_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            start_reg   <= '0;
            allowed_reg <= 1'b1;
            active_reg  <= 1'b0;
            index_reg   <= '0;
            digits_reg  <= '0;
            value_reg   <= '0;
        end else if (step_en) begin
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            allowed_reg <= allowed_next;
            active_reg  <= active_next;
            index_reg   <= index_next;
            digits_reg  <= digits_next;
            value_reg   <= value_next;
        end
    end

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && emit) |-> (match.match_length >= LENGTH_W'(7)))
        else $error("match length below seven");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && item.last_byte) |=> (!active_reg && allowed_reg && pos_reg == '0))
        else $error("end of text did not clear parser");

    a_value_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (value_reg <= OCTET_W'(999) && digits_reg <= DIGITS_MAX))
        else $error("octet accumulator out of range");

endmodule

`default_nettype wire

>>> rtl/ipv4ad_out_reg.sv
// Result register of the IPv4 address detector: holds one match until transfer.
// Depends on ipv4ad_pkg.
`default_nettype none

module ipv4ad_out_reg (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire ipv4ad_pkg::match_t  match,
    output logic                     free,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [ipv4ad_pkg::M_TDATA_W-1:0] m_tdata
);
    import ipv4ad_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    match_t match_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            match_reg <= match;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, match_reg.match_length, match_reg.match_offset};

endmodule

`default_nettype wire

>>> rtl/ipv4_address_detector_core.sv
// Top level of the IPv4 dotted-quad address detector.
// Depends on ipv4ad_pkg, ipv4ad_in_reg, ipv4ad_parse and ipv4ad_out_reg.
//
// Usage:
//   Text enters on the s_ channel, one byte per transfer, with s_tlast on the
//   final byte of each text. Every dotted-quad address found leaves on the
//   m_ channel as one transfer carrying its start offset and length.
//   A match is produced by the byte that ends it: the terminating
//   byte, or the last byte of the text.
//   A match is valid on m_tvalid once the byte that ends it has left the
//   input register and its match has been loaded into the result register.
//   Throughput: one byte per cycle unless a match waits for a stalled receiver.
//   A stalled receiver holds the result register; bytes that produce no
//   match keep flowing, and the first byte that would produce a second match
//   waits in the input register, which then deasserts s_tready.
//   Reset (aresetn low, synchronous) empties both registers, sets the byte
//   position to zero and allows an address to start at the first byte.
//   Offsets count from the start of each text modulo 2^POSITION_BITS, cut to 32 bits.
`default_nettype none

module ipv4_address_detector_core #(
    parameter int unsigned POSITION_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [ipv4ad_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] text_byte
    input  wire logic        s_tlast,                       // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [ipv4ad_pkg::M_TDATA_W-1:0] m_tdata  // [31:0] match_offset, [35:32] match_length
);
    import ipv4ad_pkg::*;

    text_item_t s_item;
    text_item_t item;
    logic       item_valid;
    logic       advance;
    logic       emit;
    logic       out_free;
    match_t     match;

    assign s_item.text_byte = s_tdata[TEXT_W-1:0];
    assign s_item.last_byte = s_tlast;

    assign advance = item_valid && (out_free || !emit);

    ipv4ad_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ipv4ad_parse #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (item),
        .emit    (emit),
        .match   (match)
    );

    ipv4ad_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && emit),
        .match    (match),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !(advance && emit))
        else $error("pending match overwritten");

    a_hold_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && emit && !out_free) |-> !s_tready)
        else $error("input taken while parser is blocked");

endmodule

`default_nettype wire
